// ===== sv/srma_pkg.sv =====
// ----------------------------------------------------------------------------
// srma_pkg
// Shared widths, request codes and defaults for the sparse row merge adder.
// ----------------------------------------------------------------------------
`default_nettype none

package srma_pkg;

    localparam int ROW_CAP_DEFAULT = 32;

    localparam int REQ_W = 2;
    localparam int COL_W = 31;
    localparam int VAL_W = 32;
    localparam int ENTRY_W = COL_W + VAL_W;

    localparam logic [REQ_W-1:0] REQ_LOAD_A  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_B  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ROW_END = 2'd2;

    typedef logic [ENTRY_W-1:0] entry_t;

endpackage

`default_nettype wire

// ===== sv/sparse_row_merge_add.sv =====
// ----------------------------------------------------------------------------
// sparse_row_merge_add
// Row-by-row CSR matrix addition: buffers A and B entries of a row, then
// merges them by column with a saturated Q16.16 sum on equal columns.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall): req_type selects a load of an A
//   entry, a load of a B entry, or the end of a row. Loads produce no result
//   and are accepted whenever the block is idle.
//   An end-of-row request starts the merge. While merging, req_stall is high.
//   Result channel (res_valid / res_stall): one result per merged column, or
//   one marker with out_valid_entry low for an empty row. The last result of
//   a row carries last_in_row, the running entry count and matrix_done.
//   The end-of-row request moves the block to a read state, where the entry
//   memories are read into their output registers, then to an emit state
//   that compares the columns, forms the sum and registers the result; each
//   further result passes through both states again. The request side stays
//   busy until the last result is registered. Results leave through an output
//   register, so the next row's loads are taken while the last result waits.
//   While res_stall holds a pending result, the merge waits with it in place.
//   Reset clears the fill counts, row and entry counters and sets row_count
//   to 1; entry memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_row_merge_add #(
    parameter int ROW_CAP = srma_pkg::ROW_CAP_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        row_count_we,
    input  wire logic [srma_pkg::COL_W-1:0]  row_count_data,
    input  wire logic                        req_valid,
    output logic                             req_stall,
    input  wire logic [srma_pkg::REQ_W-1:0]  req_type,
    input  wire logic [srma_pkg::COL_W-1:0]  column,
    input  wire logic signed [srma_pkg::VAL_W-1:0] entry_value,
    output logic                             res_valid,
    input  wire logic                        res_stall,
    output logic                             out_valid_entry,
    output logic [srma_pkg::COL_W-1:0]       out_column,
    output logic signed [srma_pkg::VAL_W-1:0] out_value,
    output logic                             last_in_row,
    output logic [srma_pkg::COL_W-1:0]       row_end_count,
    output logic [srma_pkg::COL_W-1:0]       row_number,
    output logic                             matrix_done,
    output logic                             row_overflow
);

    import srma_pkg::*;

    localparam int IDX_W = (ROW_CAP > 1) ? $clog2(ROW_CAP) : 1;
    localparam int CNT_W = $clog2(ROW_CAP + 1);
    localparam logic [CNT_W-1:0] CAP = CNT_W'(ROW_CAP);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EMIT
    } state_t;

    state_t state_reg;

    entry_t mem_a [ROW_CAP];
    entry_t mem_b [ROW_CAP];
    entry_t a_rd_reg;
    entry_t b_rd_reg;

    logic [COL_W-1:0] row_count_reg;
    logic [CNT_W-1:0] a_fill_reg;
    logic [CNT_W-1:0] b_fill_reg;
    logic [CNT_W-1:0] ia_reg;
    logic [CNT_W-1:0] ib_reg;
    logic [COL_W-1:0] total_reg;
    logic [COL_W-1:0] row_reg;
    logic             overflow_reg;

    logic                     res_valid_reg;
    logic                     out_valid_entry_reg;
    logic [COL_W-1:0]         out_column_reg;
    logic signed [VAL_W-1:0]  out_value_reg;
    logic                     last_in_row_reg;
    logic [COL_W-1:0]         row_end_count_reg;
    logic [COL_W-1:0]         row_number_reg;
    logic                     matrix_done_reg;
    logic                     row_overflow_reg;

    logic             req_take;
    logic             load_a;
    logic             load_b;
    logic             slot_free;
    logic             a_has;
    logic             b_has;
    logic [COL_W-1:0] ca;
    logic [COL_W-1:0] cb;
    logic [VAL_W-1:0] va;
    logic [VAL_W-1:0] vb;
    logic [VAL_W:0]   sum_wide;
    logic [VAL_W-1:0] sum_sat;
    logic             take_a;
    logic             take_b;
    logic             any_entry;
    logic [CNT_W-1:0] ia_next;
    logic [CNT_W-1:0] ib_next;
    logic             row_last;
    logic             mat_done;
    logic [COL_W-1:0] total_next;
    logic [COL_W-1:0] pick_col;
    logic [VAL_W-1:0] pick_val;

    assign req_stall = (state_reg != S_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign load_a    = req_take && (req_type == REQ_LOAD_A) && (a_fill_reg < CAP);
    assign load_b    = req_take && (req_type == REQ_LOAD_B) && (b_fill_reg < CAP);
    assign slot_free = !res_valid_reg || !res_stall;

    // entry memories: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (load_a)
        begin
            mem_a[a_fill_reg[IDX_W-1:0]] <= {column, entry_value};
        end
        a_rd_reg <= mem_a[ia_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (load_b)
        begin
            mem_b[b_fill_reg[IDX_W-1:0]] <= {column, entry_value};
        end
        b_rd_reg <= mem_b[ib_reg[IDX_W-1:0]];
    end

    always_comb
    begin
        a_has    = (ia_reg < a_fill_reg);
        b_has    = (ib_reg < b_fill_reg);
        ca       = a_rd_reg[ENTRY_W-1:VAL_W];
        va       = a_rd_reg[VAL_W-1:0];
        cb       = b_rd_reg[ENTRY_W-1:VAL_W];
        vb       = b_rd_reg[VAL_W-1:0];
        sum_wide = {va[VAL_W-1], va} + {vb[VAL_W-1], vb};
        if (sum_wide[VAL_W] != sum_wide[VAL_W-1])
        begin
            sum_sat = sum_wide[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}}
                                      : {1'b0, {(VAL_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[VAL_W-1:0];
        end

        take_a = a_has && (!b_has || (ca <= cb));
        take_b = b_has && (!a_has || (cb <= ca));
        any_entry = a_has || b_has;

        ia_next = take_a ? ia_reg + CNT_W'(1) : ia_reg;
        ib_next = take_b ? ib_reg + CNT_W'(1) : ib_reg;
        row_last = !((ia_next < a_fill_reg) || (ib_next < b_fill_reg));

        if (take_a && take_b)
        begin
            pick_col = ca;
            pick_val = sum_sat;
        end
        else if (take_a)
        begin
            pick_col = ca;
            pick_val = va;
        end
        else if (take_b)
        begin
            pick_col = cb;
            pick_val = vb;
        end
        else
        begin
            pick_col = '0;
            pick_val = '0;
        end

        total_next = any_entry ? total_reg + COL_W'(1) : total_reg;
        mat_done   = ({1'b0, row_reg} + (COL_W+1)'(1)) >= {1'b0, row_count_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            row_count_reg       <= COL_W'(1);
            a_fill_reg          <= '0;
            b_fill_reg          <= '0;
            ia_reg              <= '0;
            ib_reg              <= '0;
            total_reg           <= '0;
            row_reg             <= '0;
            overflow_reg        <= 1'b0;
            res_valid_reg       <= 1'b0;
            out_valid_entry_reg <= 1'b0;
            out_column_reg      <= '0;
            out_value_reg       <= '0;
            last_in_row_reg     <= 1'b0;
            row_end_count_reg   <= '0;
            row_number_reg      <= '0;
            matrix_done_reg     <= 1'b0;
            row_overflow_reg    <= 1'b0;
        end
        else
        begin
            if (row_count_we)
            begin
                row_count_reg <= row_count_data;
            end
            if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_take)
                    begin
                        unique case (req_type)
                            REQ_LOAD_A:
                            begin
                                if (a_fill_reg < CAP)
                                    a_fill_reg <= a_fill_reg + CNT_W'(1);
                                else
                                    overflow_reg <= 1'b1;
                            end
                            REQ_LOAD_B:
                            begin
                                if (b_fill_reg < CAP)
                                    b_fill_reg <= b_fill_reg + CNT_W'(1);
                                else
                                    overflow_reg <= 1'b1;
                            end
                            REQ_ROW_END:
                            begin
                                ia_reg    <= '0;
                                ib_reg    <= '0;
                                state_reg <= S_READ;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_READ:
                begin
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (slot_free)
                    begin
                        res_valid_reg       <= 1'b1;
                        out_valid_entry_reg <= any_entry;
                        out_column_reg      <= pick_col;
                        out_value_reg       <= pick_val;
                        last_in_row_reg     <= row_last;
                        row_end_count_reg   <= row_last ? total_next : '0;
                        row_number_reg      <= row_reg;
                        matrix_done_reg     <= row_last && mat_done;
                        row_overflow_reg    <= overflow_reg;
                        ia_reg              <= ia_next;
                        ib_reg              <= ib_next;
                        total_reg           <= total_next;
                        if (row_last)
                        begin
                            a_fill_reg   <= '0;
                            b_fill_reg   <= '0;
                            ia_reg       <= '0;
                            ib_reg       <= '0;
                            overflow_reg <= 1'b0;
                            if (mat_done)
                            begin
                                total_reg <= '0;
                                row_reg   <= '0;
                            end
                            else
                            begin
                                row_reg <= row_reg + COL_W'(1);
                            end
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res_valid       = res_valid_reg;
    assign out_valid_entry = out_valid_entry_reg;
    assign out_column      = out_column_reg;
    assign out_value       = out_value_reg;
    assign last_in_row     = last_in_row_reg;
    assign row_end_count   = row_end_count_reg;
    assign row_number      = row_number_reg;
    assign matrix_done     = matrix_done_reg;
    assign row_overflow    = row_overflow_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (a_fill_reg <= CAP) && (b_fill_reg <= CAP))
        else $error("fill count beyond row capacity");

    ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> ((ia_reg <= a_fill_reg) && (ib_reg <= b_fill_reg)))
        else $error("merge pointer past fill count");

    done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && matrix_done) |-> last_in_row)
        else $error("matrix_done without last_in_row");

    marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !out_valid_entry) |-> last_in_row)
        else $error("empty-row marker not last in row");

    no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall && (state_reg == S_EMIT)) |=> $stable(out_column))
        else $error("pending result overwritten");

endmodule

`default_nettype wire
